/* hw/rtl/cmmn_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and codes for the column min/max normalizer.
// No dependencies; every other file in hw/rtl imports this package.
package cmmn_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int NORM_W   = 17;
  localparam int COLUMN_W = 4;
  localparam int CFG_W    = 5;
  localparam int FRAC_W   = 16;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // Parameter defaults
  localparam int MAX_ELEMENTS_DEF = 4096;
  localparam int MAX_COLUMNS_DEF  = 16;

  // Reset values
  localparam logic [CFG_W-1:0]           COLUMN_COUNT_RST = 5'd1;
  localparam logic signed [SAMPLE_W-1:0] MIN_RST          = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] MAX_RST          = 16'sh8000;
  localparam logic [NORM_W-1:0]          NORM_ONE         = 17'h10000;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_FETCH = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DRAINING = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FLAT     = 3'd4
  } status_t;

  typedef enum logic {
    REG_COLUMN_COUNT = 1'b0
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_RD,
    S_EVAL,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    func_t                       func;
    logic signed [SAMPLE_W-1:0]  sample;
  } req_t;

  typedef struct packed {
    logic [NORM_W-1:0]   norm_value;
    logic [COLUMN_W-1:0] column;
    logic                last;
    status_t             status;
  } rsp_t;

  // Address width for a store of the given depth (at least one bit)
  function automatic int addr_bits(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

/* hw/rtl/cmmn_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on cmmn_pkg for the address width helper.
module cmmn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = cmmn_pkg::addr_bits(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  import cmmn_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/cmmn_div.sv */
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Used both for index-mod-columns and for the Q0.16 fraction; uses cmmn_pkg.
module cmmn_div #(
  parameter int DVD_W = 16,
  parameter int DIV_W = 16,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] rem_init,
  input  logic [DIV_W-1:0] divisor,
  input  logic [DVD_W-1:0] dividend,
  input  logic [CNT_W-1:0] steps,
  output logic             done,
  output logic [DIV_W-1:0] rem,
  output logic [DVD_W-1:0] quo
);
  import cmmn_pkg::*;

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [DIV_W-1:0] div_q;

  logic [DIV_W:0]   r2;
  logic [DIV_W:0]   r_sub;
  logic             ge;

  // One restoring step: shift in the next dividend bit, try subtract
  always_comb begin
    r2    = {rem_q, quo_q[DVD_W-1]};
    ge    = (r2 >= {1'b0, div_q});
    r_sub = r2 - {1'b0, div_q};
  end

  assign done = active && (cnt == '0);
  assign rem  = rem_q;
  assign quo  = quo_q;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      active <= 1'b1;
      cnt    <= steps;
    end else if (active) begin
      if (cnt == '0) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= rem_init;
      quo_q <= dividend;
      div_q <= divisor;
    end else if (active && (cnt != '0)) begin
      rem_q <= ge ? r_sub[DIV_W-1:0] : r2[DIV_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  // No restart while a division is in flight
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !active)
    else $error("divider restarted while busy");

  // A run with steps left keeps going
  a_keeps_running: assert property (@(posedge clk) disable iff (rst)
    (active && (cnt != '0) && !start) |=> active)
    else $error("divider stopped early");

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> (rem_q < div_q))
    else $error("partial remainder out of range");

endmodule

/* hw/rtl/column_minmax_normalizer.sv */
`timescale 1ns / 1ps
// Top level of the column min/max normalizer: control FSM, config register,
// sample store and per-column min/max store. Uses cmmn_pkg, cmmn_ram, cmmn_div.
//
// Usage:
//   Requests enter on req (func, sample) when start is high and busy is low.
//   Each request gives exactly one response on rsp, marked by done for one
//   cycle; the receiver cannot stall, so the response must be taken then.
//   column_count is set through the APB port (address 0, low 5 bits).
// Sequencing (one request at a time, busy until the response):
//   refused load or empty fetch:   S_IDLE straight to S_DONE
//   accepted load:                 S_MOD, S_RD, S_EVAL, S_DONE
//   fetch, clamped or flat column: S_MOD, S_RD, S_EVAL, S_DONE
//   fetch needing a quotient:      S_MOD, S_RD, S_EVAL, S_DIV, S_DONE
//   The column is found by a bit-serial remainder of the element index over
//   the column count, and the fraction by 16 more steps of the same divider.
// Reset clears the table (counts, drain flag, column valid bits) at once and
// sets column_count to 1; the sample store needs no clearing.
module column_minmax_normalizer #(
  parameter int MAX_ELEMENTS = cmmn_pkg::MAX_ELEMENTS_DEF,
  parameter int MAX_COLUMNS  = cmmn_pkg::MAX_COLUMNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  cmmn_pkg::req_t                req,
  output logic                          done,
  output cmmn_pkg::rsp_t                rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmmn_pkg::ADDR_W-1:0]   paddr,
  input  logic [cmmn_pkg::DATA_W-1:0]   pwdata,
  output logic [cmmn_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import cmmn_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int SAW    = addr_bits(MAX_ELEMENTS);
  localparam int CIDX_W = addr_bits(MAX_COLUMNS);
  localparam int DIV_W  = SAMPLE_W;
  localparam int DVD_W  = (IDX_W > FRAC_W) ? IDX_W : FRAC_W;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int MM_W   = 2 * SAMPLE_W;

  localparam logic [IDX_W-1:0] IDX_FULL    = IDX_W'(MAX_ELEMENTS);
  localparam logic [DIV_W-1:0] MAX_COLS_D  = DIV_W'(MAX_COLUMNS);
  localparam logic [CNT_W-1:0] MOD_STEPS   = CNT_W'(IDX_W);
  localparam logic [CNT_W-1:0] FRAC_STEPS  = CNT_W'(FRAC_W);

  // Control state
  state_t                state, state_next;
  logic [CFG_W-1:0]      column_count;
  logic [IDX_W-1:0]      loaded_count;
  logic [IDX_W-1:0]      fetch_ptr;
  logic                  draining;
  logic [MAX_COLUMNS-1:0] col_valid;

  // Per-request payload
  func_t                     func_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic [CIDX_W-1:0]         col_q;
  rsp_t                      rsp_q;

  // Handshake and decode
  logic                accept;
  logic                immediate;
  status_t             imm_status;
  logic [DIV_W-1:0]    eff_cols;
  logic [IDX_W-1:0]    index_sel;
  logic [IDX_W-1:0]    fetch_ptr_inc;
  logic                fetch_last;
  logic                cfg_write;

  // Evaluation of one element against its column range
  logic signed [SAMPLE_W-1:0] mn, mx;
  logic signed [SAMPLE_W-1:0] new_min, new_max;
  logic [SAMPLE_W:0]          diff_x, diff_r;
  logic                       flat, sat_lo, sat_hi, needs_div;

  // Divider interface
  logic             div_start;
  logic [DIV_W-1:0] div_rem_init;
  logic [DIV_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_dividend;
  logic [CNT_W-1:0] div_steps;
  logic             div_done;
  logic [DIV_W-1:0] div_rem;
  logic [DVD_W-1:0] div_quo;

  // Memory interfaces
  logic                st_we, st_re;
  logic [SAW-1:0]      st_waddr, st_raddr;
  logic [SAMPLE_W-1:0] st_wdata, st_rdata;
  logic                mm_we, mm_re;
  logic [CIDX_W-1:0]   mm_waddr, mm_raddr;
  logic [MM_W-1:0]     mm_wdata, mm_rdata;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign done   = (state == S_DONE);
  assign rsp    = rsp_q;

  // APB: always ready, one register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_COLUMN_COUNT);
  assign prdata    = (paddr[2] == REG_COLUMN_COUNT) ? DATA_W'(column_count) : '0;

  // Effective column count: zero acts as one, clamp to MAX_COLUMNS
  always_comb begin
    if (column_count == '0) begin
      eff_cols = DIV_W'(1);
    end else if (DIV_W'(column_count) > MAX_COLS_D) begin
      eff_cols = MAX_COLS_D;
    end else begin
      eff_cols = DIV_W'(column_count);
    end
  end

  // Request decode in idle
  always_comb begin
    index_sel  = (req.func == FUNC_LOAD) ? loaded_count : fetch_ptr;
    imm_status = ST_OK;
    immediate  = 1'b0;
    if (req.func == FUNC_LOAD) begin
      if (draining) begin
        immediate  = 1'b1;
        imm_status = ST_DRAINING;
      end else if (loaded_count >= IDX_FULL) begin
        immediate  = 1'b1;
        imm_status = ST_FULL;
      end
    end else if (fetch_ptr >= loaded_count) begin
      immediate  = 1'b1;
      imm_status = ST_EMPTY;
    end
  end

  // Column range check and min/max update
  always_comb begin
    mn = col_valid[col_q] ? $signed(mm_rdata[MM_W-1 -: SAMPLE_W]) : MIN_RST;
    mx = col_valid[col_q] ? $signed(mm_rdata[SAMPLE_W-1:0]) : MAX_RST;
    new_min   = (x_q < mn) ? x_q : mn;
    new_max   = (x_q > mx) ? x_q : mx;
    diff_x    = {x_q[SAMPLE_W-1], x_q} - {mn[SAMPLE_W-1], mn};
    diff_r    = {mx[SAMPLE_W-1], mx} - {mn[SAMPLE_W-1], mn};
    flat      = (mx <= mn);
    sat_lo    = (x_q <= mn);
    sat_hi    = (x_q >= mx);
    needs_div = !flat && !sat_lo && !sat_hi;
    fetch_ptr_inc = fetch_ptr + 1'b1;
    fetch_last    = (fetch_ptr_inc >= loaded_count);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = immediate ? S_DONE : S_MOD;
        end
      end
      S_MOD: begin
        if (div_done) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = ((func_q == FUNC_FETCH) && needs_div) ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Memory and divider controls
  always_comb begin
    div_start    = 1'b0;
    div_rem_init = '0;
    div_divisor  = eff_cols;
    div_dividend = DVD_W'(index_sel) << (DVD_W - IDX_W);
    div_steps    = MOD_STEPS;
    st_we        = 1'b0;
    st_waddr     = loaded_count[SAW-1:0];
    st_wdata     = req.sample;
    st_re        = 1'b0;
    st_raddr     = fetch_ptr[SAW-1:0];
    mm_re        = 1'b0;
    mm_raddr     = div_rem[CIDX_W-1:0];
    mm_we        = 1'b0;
    mm_waddr     = col_q;
    mm_wdata     = {new_min, new_max};
    case (state)
      S_IDLE: begin
        if (accept && !immediate) begin
          div_start = 1'b1;
          st_we     = (req.func == FUNC_LOAD);
          st_re     = (req.func == FUNC_FETCH);
        end
      end
      S_MOD: begin
        mm_re = div_done;
      end
      S_EVAL: begin
        if (func_q == FUNC_LOAD) begin
          mm_we = 1'b1;
        end else if (needs_div) begin
          div_start    = 1'b1;
          div_rem_init = diff_x[DIV_W-1:0];
          div_divisor  = diff_r[DIV_W-1:0];
          div_dividend = '0;
          div_steps    = FRAC_STEPS;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_count <= COLUMN_COUNT_RST;
      loaded_count <= '0;
      fetch_ptr    <= '0;
      draining     <= 1'b0;
      col_valid    <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        column_count <= pwdata[CFG_W-1:0];
      end
      if (state == S_EVAL) begin
        if (func_q == FUNC_LOAD) begin
          loaded_count     <= loaded_count + 1'b1;
          col_valid[col_q] <= 1'b1;
        end else if (fetch_last) begin
          loaded_count <= '0;
          fetch_ptr    <= '0;
          draining     <= 1'b0;
          col_valid    <= '0;
        end else begin
          fetch_ptr <= fetch_ptr_inc;
          draining  <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          func_q <= req.func;
          x_q    <= req.sample;
          rsp_q  <= '{norm_value: '0, column: '0, last: 1'b0, status: imm_status};
        end
      end
      S_MOD: begin
        if (div_done) begin
          col_q <= div_rem[CIDX_W-1:0];
          if (func_q == FUNC_FETCH) begin
            x_q <= $signed(st_rdata);
          end
        end
      end
      S_EVAL: begin
        rsp_q.column <= COLUMN_W'(col_q);
        if (func_q == FUNC_LOAD) begin
          rsp_q.norm_value <= '0;
          rsp_q.last       <= 1'b0;
          rsp_q.status     <= ST_OK;
        end else begin
          rsp_q.last       <= fetch_last;
          rsp_q.status     <= flat ? ST_FLAT : ST_OK;
          rsp_q.norm_value <= (!flat && !sat_lo && sat_hi) ? NORM_ONE : '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          rsp_q.norm_value <= NORM_W'(div_quo[FRAC_W-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  // Shared divider
  cmmn_div #(
    .DVD_W (DVD_W),
    .DIV_W (DIV_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .divisor  (div_divisor),
    .dividend (div_dividend),
    .steps    (div_steps),
    .done     (div_done),
    .rem      (div_rem),
    .quo      (div_quo)
  );

  // Sample store
  cmmn_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_sample_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Per-column {min, max}
  cmmn_ram #(
    .WIDTH (MM_W),
    .DEPTH (MAX_COLUMNS)
  ) u_minmax_ram (
    .clk   (clk),
    .we    (mm_we),
    .waddr (mm_waddr),
    .wdata (mm_wdata),
    .re    (mm_re),
    .raddr (mm_raddr),
    .rdata (mm_rdata)
  );

  // A response strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("response strobe longer than one cycle");

  // An accepted request holds the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("not busy after accepting a request");

  // Fetch pointer never passes the loaded count
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    fetch_ptr <= loaded_count)
    else $error("fetch pointer beyond loaded count");

  // Draining only with a table present
  a_drain_table: assert property (@(posedge clk) disable iff (rst)
    draining |-> (loaded_count != '0))
    else $error("draining with an empty table");

  // The final fetch leaves the table empty
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.last) |=> ((loaded_count == '0) && !draining))
    else $error("table not cleared after the final fetch");

endmodule
